>>> rtl/rspq_pkg.sv
`default_nettype none
package rspq_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_W    = 12;
  localparam int RAMP_W      = 12;
  localparam int CNT_W       = 8;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);
  localparam logic [RAMP_W-1:0] RAMP_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic [SAMPLE_W-1:0] TRIGGER_RST   = 12'd2048;
  localparam logic [SAMPLE_W-1:0] VALID_AMP_RST = 12'd3000;
  localparam logic [CNT_W-1:0]    ALARM_LIM_RST = 8'd20;
  localparam logic [RAMP_W-1:0]   WIDTH_LIM_RST = 12'd420;
  localparam logic [RAMP_W-1:0]   RAMP_LOW_RST  = 12'd400;
  localparam logic [RAMP_W-1:0]   RAMP_HIGH_RST = 12'd1600;
  localparam logic [CNT_W-1:0]    RAMP_STEP_RST = 8'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER   = 3'd0,
    REG_VALID_AMP = 3'd1,
    REG_ALARM_LIM = 3'd2,
    REG_WIDTH_LIM = 3'd3,
    REG_RAMP_LOW  = 3'd4,
    REG_RAMP_HIGH = 3'd5,
    REG_RAMP_STEP = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_PULSE = 2'd1,
    PH_ENDED = 2'd2,
    PH_SPARE = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [SAMPLE_W-1:0]   peak;
    logic [RAMP_W-1:0]     start;
    logic [RAMP_W-1:0]     stop;
  } pulse_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] trigger;
    logic [SAMPLE_W-1:0] valid_amp;
    logic [RAMP_W-1:0]   width_lim;
  } track_cfg_t;

endpackage
`default_nettype wire

>>> rtl/rspq_pulse_track.sv
`default_nettype none
module rspq_pulse_track
  import rspq_pkg::*;
(
  input  wire pulse_t              pulse_in,
  input  wire track_cfg_t          cfg,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [RAMP_W-1:0]   ramp,
  output pulse_t                   pulse_out,
  output logic                     good
);

  logic [RAMP_W-1:0] width;

  always_comb begin
    pulse_out = pulse_in;
    case (pulse_in.phase)
      PH_WAIT: begin
        if (sample > cfg.trigger) begin
          pulse_out.phase = PH_PULSE;
          pulse_out.start = ramp;
          if (sample > pulse_in.peak) begin
            pulse_out.peak = sample;
          end
        end
      end
      PH_PULSE: begin
        if (sample > pulse_in.peak) begin
          pulse_out.peak = sample;
        end else if (sample < cfg.trigger) begin
          pulse_out.phase = PH_ENDED;
          pulse_out.stop  = ramp;
        end
      end
      default: ;
    endcase
  end

  // width uses the tracked edges of this same tick
  always_comb begin
    if (pulse_out.stop >= pulse_out.start) begin
      width = pulse_out.stop - pulse_out.start;
    end else begin
      width = pulse_out.start - pulse_out.stop;
    end
    good = (pulse_out.peak > cfg.valid_amp) && (pulse_out.phase == PH_ENDED) &&
           (width < cfg.width_lim);
  end

endmodule
`default_nettype wire

>>> rtl/ramp_sweep_pulse_qualifier_top.sv
`default_nettype none
// Ramp sweep pulse qualifier. Each input item is a command (tick with sample, start,
// stop, clear alarm) and yields exactly one result item carrying the ramp level, the
// sweep-end and pulse-good flags, the sticky alarm, the detect flag and the miss count.
// For every item the state update and the result are computed in one pass of compare
// and add logic and the result lands in an output register, so one item per cycle is
// sustained as long as the result side keeps taking items. The user must write registers
// through the cfg port only while no item is in flight; the block does not enforce it.
module ramp_sweep_pulse_qualifier_top
  import rspq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,  // [11:0] sample, [15:12] zero
  input  wire logic [CMD_W-1:0]      in_tuser,  // [1:0] cmd
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [11:0] ramp_level, [12] sweep_end, [13] pulse_good, [14] alarm,
  // [15] air_detected, [23:16] miss_count
  output logic [23:0]                out_tdata
);

  logic [SAMPLE_W-1:0] trigger_r, valid_amp_r;
  logic [CNT_W-1:0]    alarm_lim_r, ramp_step_r;
  logic [RAMP_W-1:0]   width_lim_r, ramp_low_r, ramp_high_r;

  logic                enabled_r, enabled_nxt;
  logic                down_r, down_nxt;
  logic                alarm_r, alarm_nxt;
  logic [RAMP_W-1:0]   ramp_r, ramp_nxt;
  pulse_t              pulse_r, pulse_nxt, pulse_trk;
  logic [CNT_W-1:0]    miss_r, miss_nxt;
  logic [CNT_W-1:0]    detect_r, detect_nxt;

  logic                out_valid_r;
  logic [23:0]         out_data_r, out_data_nxt;

  logic                in_acc;
  cmd_t                cmd;
  logic [SAMPLE_W-1:0] sample;
  logic                good, ended, good_nxt;
  logic [RAMP_W:0]     ramp_up;
  track_cfg_t          tcfg;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cmd    = cmd_t'(in_tuser);
  assign sample = in_tdata[SAMPLE_W-1:0] & SAMPLE_MASK;

  assign tcfg.trigger   = trigger_r;
  assign tcfg.valid_amp = valid_amp_r;
  assign tcfg.width_lim = width_lim_r;

  rspq_pulse_track u_track (
    .pulse_in  (pulse_r),
    .cfg       (tcfg),
    .sample    (sample),
    .ramp      (ramp_r),
    .pulse_out (pulse_trk),
    .good      (good)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r   <= TRIGGER_RST;
      valid_amp_r <= VALID_AMP_RST;
      alarm_lim_r <= ALARM_LIM_RST;
      width_lim_r <= WIDTH_LIM_RST;
      ramp_low_r  <= RAMP_LOW_RST;
      ramp_high_r <= RAMP_HIGH_RST;
      ramp_step_r <= RAMP_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_TRIGGER:   trigger_r   <= cfg_data[SAMPLE_W-1:0];
        REG_VALID_AMP: valid_amp_r <= cfg_data[SAMPLE_W-1:0];
        REG_ALARM_LIM: alarm_lim_r <= cfg_data[CNT_W-1:0];
        REG_WIDTH_LIM: width_lim_r <= cfg_data[RAMP_W-1:0];
        REG_RAMP_LOW:  ramp_low_r  <= cfg_data[RAMP_W-1:0];
        REG_RAMP_HIGH: ramp_high_r <= cfg_data[RAMP_W-1:0];
        REG_RAMP_STEP: ramp_step_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ramp_up = {1'b0, ramp_r} + {{(RAMP_W + 1 - CNT_W){1'b0}}, ramp_step_r};

  always_comb begin
    enabled_nxt = enabled_r;
    down_nxt    = down_r;
    alarm_nxt   = alarm_r;
    ramp_nxt    = ramp_r;
    pulse_nxt   = pulse_r;
    miss_nxt    = miss_r;
    detect_nxt  = detect_r;
    ended       = 1'b0;
    good_nxt    = 1'b0;
    case (cmd)
      CMD_START: begin
        pulse_nxt.peak  = sample;
        pulse_nxt.phase = PH_WAIT;
        miss_nxt        = '0;
        enabled_nxt     = 1'b1;
        down_nxt        = 1'b0;
        ramp_nxt        = ramp_low_r;
      end
      CMD_STOP:  enabled_nxt = 1'b0;
      CMD_CLEAR: alarm_nxt   = 1'b0;
      default: begin
        if (enabled_r) begin
          pulse_nxt = pulse_trk;
          if (!down_r && ramp_r < ramp_high_r) begin
            ramp_nxt = ramp_up[RAMP_W] ? RAMP_MAX : ramp_up[RAMP_W-1:0];
          end else if (down_r && ramp_r > ramp_low_r) begin
            ramp_nxt = (ramp_r >= RAMP_W'(ramp_step_r)) ? ramp_r - RAMP_W'(ramp_step_r)
                                                       : '0;
          end else begin
            // turning point: judge the sweep, then start a fresh one
            ended    = 1'b1;
            good_nxt = good;
            down_nxt = !down_r;
            if (good) begin
              miss_nxt   = '0;
              detect_nxt = '0;
            end else if (miss_r < alarm_lim_r) begin
              miss_nxt = miss_r + CNT_W'(1);
            end else begin
              if (detect_r != CNT_MAX) begin
                detect_nxt = detect_r + CNT_W'(1);
              end
              alarm_nxt = 1'b1;
            end
            pulse_nxt.peak  = sample;
            pulse_nxt.start = '0;
            pulse_nxt.stop  = '0;
            pulse_nxt.phase = PH_WAIT;
          end
        end
      end
    endcase
    out_data_nxt = {miss_nxt, (detect_nxt != '0), alarm_nxt, good_nxt, ended, ramp_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      down_r      <= 1'b0;
      alarm_r     <= 1'b0;
      ramp_r      <= RAMP_LOW_RST;
      pulse_r     <= '{phase: PH_WAIT, peak: '0, start: '0, stop: '0};
      miss_r      <= '0;
      detect_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        enabled_r <= enabled_nxt;
        down_r    <= down_nxt;
        alarm_r   <= alarm_nxt;
        ramp_r    <= ramp_nxt;
        pulse_r   <= pulse_nxt;
        miss_r    <= miss_nxt;
        detect_r  <= detect_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

>>> test/rspq_sweep_checker.sv
`timescale 1ns / 1ps
module rspq_sweep_checker
  import rspq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [11:0] sample, [15:12] zero
  input  logic [CMD_W-1:0]      in_tuser,   // [1:0] cmd
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [11:0] ramp_level, [12] sweep_end, [13] pulse_good, [14] alarm,
  // [15] air_detected, [23:16] miss_count
  input  logic [23:0]           out_tdata,
  output int unsigned           mismatch_count,
  output int unsigned           results_pending
);

  typedef struct packed {
    logic [CNT_W-1:0]  miss;
    logic              air;
    logic              alarm;
    logic              good;
    logic              ended;
    logic [RAMP_W-1:0] ramp;
  } sweep_result_t;

  sweep_result_t expected_results[$];
  int unsigned   fails;

  // register copies
  logic [SAMPLE_W-1:0] trig_lvl, valid_amp;
  logic [CNT_W-1:0]    alarm_lim, ramp_step;
  logic [RAMP_W-1:0]   width_lim, ramp_low, ramp_high;

  // sweep state
  logic                sweeping, going_down, alarm_flag;
  logic [RAMP_W-1:0]   ramp, edge_start, edge_stop;
  logic [SAMPLE_W-1:0] peak;
  phase_t              phase;
  logic [CNT_W-1:0]    miss_cnt, detect_cnt;

  function automatic void follow_pulse(input logic [SAMPLE_W-1:0] smp);
    if (phase == PH_WAIT) begin
      if (smp > trig_lvl) begin
        phase      = PH_PULSE;
        edge_start = ramp;
        if (smp > peak) peak = smp;
      end
    end else if (phase == PH_PULSE) begin
      if (smp > peak) begin
        peak = smp;
      end else if (smp < trig_lvl) begin
        phase     = PH_ENDED;
        edge_stop = ramp;
      end
    end
  endfunction

  function automatic logic close_sweep(input logic [SAMPLE_W-1:0] smp);
    logic [RAMP_W-1:0] span;
    logic              ok;
    span = (edge_stop >= edge_start) ? edge_stop - edge_start : edge_start - edge_stop;
    ok   = (peak > valid_amp) && (phase == PH_ENDED) && (span < width_lim);
    if (ok) begin
      miss_cnt   = '0;
      detect_cnt = '0;
    end else if (miss_cnt < alarm_lim) begin
      miss_cnt = miss_cnt + CNT_W'(1);
    end else begin
      if (detect_cnt != CNT_MAX) detect_cnt = detect_cnt + CNT_W'(1);
      alarm_flag = 1'b1;
    end
    peak       = smp;
    edge_start = '0;
    edge_stop  = '0;
    phase      = PH_WAIT;
    return ok;
  endfunction

  function automatic sweep_result_t predict_sweep_step(input cmd_t cmd,
                                                      input logic [SAMPLE_W-1:0] raw);
    sweep_result_t       r;
    logic [SAMPLE_W-1:0] smp;
    logic [RAMP_W:0]     sum;
    smp     = raw & SAMPLE_MASK;
    r       = '0;
    case (cmd)
      CMD_START: begin
        peak       = smp;
        phase      = PH_WAIT;
        miss_cnt   = '0;
        sweeping   = 1'b1;
        going_down = 1'b0;
        ramp       = ramp_low;
      end
      CMD_STOP:  sweeping = 1'b0;
      CMD_CLEAR: alarm_flag = 1'b0;
      default: begin
        if (sweeping) begin
          follow_pulse(smp);
          if (!going_down) begin
            if (ramp < ramp_high) begin
              sum  = {1'b0, ramp} + {{(RAMP_W + 1 - CNT_W){1'b0}}, ramp_step};
              ramp = sum[RAMP_W] ? RAMP_MAX : sum[RAMP_W-1:0];
            end else begin
              r.ended    = 1'b1;
              r.good     = close_sweep(smp);
              going_down = 1'b1;
            end
          end else begin
            if (ramp > ramp_low) begin
              ramp = (ramp >= RAMP_W'(ramp_step)) ? ramp - RAMP_W'(ramp_step) : '0;
            end else begin
              r.ended    = 1'b1;
              r.good     = close_sweep(smp);
              going_down = 1'b0;
            end
          end
        end
      end
    endcase
    r.ramp  = ramp;
    r.alarm = alarm_flag;
    r.air   = (detect_cnt != '0);
    r.miss  = miss_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    sweep_result_t want, got;
    if (!rst_n) begin
      trig_lvl   = TRIGGER_RST;
      valid_amp  = VALID_AMP_RST;
      alarm_lim  = ALARM_LIM_RST;
      width_lim  = WIDTH_LIM_RST;
      ramp_low   = RAMP_LOW_RST;
      ramp_high  = RAMP_HIGH_RST;
      ramp_step  = RAMP_STEP_RST;
      sweeping   = 1'b0;
      going_down = 1'b0;
      alarm_flag = 1'b0;
      ramp       = RAMP_LOW_RST;
      phase      = PH_WAIT;
      peak       = '0;
      edge_start = '0;
      edge_stop  = '0;
      miss_cnt   = '0;
      detect_cnt = '0;
      fails      = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = sweep_result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result item with nothing expected: %h", $realtime, out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.ramp !== want.ramp || got.ended !== want.ended ||
              got.good !== want.good || got.alarm !== want.alarm ||
              got.air !== want.air || got.miss !== want.miss) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result mismatch: expected ramp %0d end %0b good %0b alarm %0b air %0b miss %0d",
                       $realtime, want.ramp, want.ended, want.good, want.alarm, want.air,
                       want.miss);
              $display("%0t: result mismatch: got ramp %0d end %0b good %0b alarm %0b air %0b miss %0d",
                       $realtime, got.ramp, got.ended, got.good, got.alarm, got.air,
                       got.miss);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          REG_TRIGGER:   trig_lvl  = cfg_data;
          REG_VALID_AMP: valid_amp = cfg_data;
          REG_ALARM_LIM: alarm_lim = cfg_data[CNT_W-1:0];
          REG_WIDTH_LIM: width_lim = cfg_data;
          REG_RAMP_LOW:  ramp_low  = cfg_data;
          REG_RAMP_HIGH: ramp_high = cfg_data;
          REG_RAMP_STEP: ramp_step = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_sweep_step(cmd_t'(in_tuser),
                                                      in_tdata[SAMPLE_W-1:0]));
    end
    mismatch_count  <= fails;
    results_pending <= expected_results.size();
  end

endmodule

>>> test/ramp_sweep_pulse_qualifier_top_tb.sv
`timescale 1ns / 1ps
module ramp_sweep_pulse_qualifier_top_tb;
  import rspq_pkg::*;

  localparam int LONG_HOLD  = 400;
  localparam int IDLE_LIMIT = 5000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [11:0] sample, [15:12] zero
  logic [CMD_W-1:0]      in_tuser;   // [1:0] cmd
  logic                  out_tvalid;
  logic                  out_tready;
  // [11:0] ramp_level, [12] sweep_end, [13] pulse_good, [14] alarm,
  // [15] air_detected, [23:16] miss_count
  logic [23:0]           out_tdata;

  int unsigned mismatch_count;
  int unsigned results_pending;

  bit steady_in, steady_out, running, hold_request;
  int cur_trig, cur_valid, pulse_left, stall_left, idle_cycles;

  ramp_sweep_pulse_qualifier_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rspq_sweep_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 60);
  endfunction

  // samples sit below the trigger, with short pulses above it now and then
  function automatic logic [11:0] next_sample();
    int floor_lvl;
    if (pulse_left == 0 && $urandom_range(0, 9) == 0) pulse_left = $urandom_range(1, 6);
    if (pulse_left > 0) begin
      pulse_left--;
      floor_lvl = ($urandom_range(0, 1) == 1) ? cur_valid + 1 : cur_trig + 1;
      if (floor_lvl > 4095) floor_lvl = 4095;
      return 12'($urandom_range(floor_lvl, 4095));
    end
    if ($urandom_range(0, 19) == 0 || cur_trig == 0) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, cur_trig - 1));
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        out_tready <= 1'b1;
      end else begin
        if (stall_left == 0 && !steady_out && $urandom_range(0, 4) == 0)
          stall_left = gap_len();
        if (stall_left > 0) begin
          out_tready <= 1'b0;
          stall_left--;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [11:0] trig, input logic [11:0] vamp,
                          input logic [7:0] alim, input logic [11:0] wlim,
                          input logic [11:0] lo, input logic [11:0] hi,
                          input logic [7:0] stp);
    write_reg(REG_TRIGGER, trig);
    write_reg(REG_VALID_AMP, vamp);
    write_reg(REG_ALARM_LIM, {4'b0, alim});
    write_reg(REG_WIDTH_LIM, wlim);
    write_reg(REG_RAMP_LOW, lo);
    write_reg(REG_RAMP_HIGH, hi);
    write_reg(REG_RAMP_STEP, {4'b0, stp});
    cur_trig  = trig;
    cur_valid = vamp;
  endtask

  task automatic put_item(input cmd_t cmd, input logic [11:0] smp);
    int gap;
    gap = steady_in ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_START) running = 1'b1;
    if (cmd == CMD_STOP) running = 1'b0;
  endtask

  // hold the sender until every expected result item is back
  task automatic wait_results;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int n, input bit kick_off, input int hold_at);
    int   done, r;
    cmd_t cmd;
    done       = 0;
    steady_in  = (hold_at >= 0) || ($urandom_range(0, 3) == 0);
    steady_out = ($urandom_range(0, 3) == 0);
    if (kick_off) put_item(CMD_START, next_sample());
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (!running) cmd = (r < 60) ? CMD_START : cmd_t'($urandom_range(0, 3));
      else if (r < 90) cmd = CMD_TICK;
      else if (r < 94) cmd = CMD_START;
      else if (r < 97) cmd = CMD_STOP;
      else cmd = CMD_CLEAR;
      if (running || cmd != CMD_TICK) done++;
      if (done == hold_at) hold_request = 1'b1;
      put_item(cmd, next_sample());
    end
  endtask

  task automatic pick_random_regs;
    int lo, hi, stp, trig;
    stp  = $urandom_range(1, 255);
    lo   = $urandom_range(0, 4095);
    hi   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                       : lo + stp * $urandom_range(0, 10);
    if (hi > 4095) hi = 4095;
    trig = $urandom_range(0, 4095);
    set_regs(12'(trig), 12'($urandom_range(trig, 4095)), 8'($urandom_range(0, 6)),
             12'(stp * $urandom_range(0, 8)), 12'(lo), 12'(hi), 8'(stp));
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_TRIGGER;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_TICK;
    steady_in    = 1'b0;
    steady_out   = 1'b0;
    running      = 1'b0;
    hold_request = 1'b0;
    cur_trig     = TRIGGER_RST;
    cur_valid    = VALID_AMP_RST;
    pulse_left   = 0;
    idle_cycles  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // short sweep 100..120 so every sweep end comes quickly
    set_regs(12'd2048, 12'd3000, 8'd2, 12'd420, 12'd100, 12'd120, 8'd5);
    put_item(CMD_TICK, 12'hFFF);   // ignored while disabled
    put_item(CMD_STOP, 12'h000);
    put_item(CMD_CLEAR, 12'hFFF);
    put_item(CMD_START, 12'h000);
    put_item(CMD_TICK, 12'h000);
    put_item(CMD_TICK, 12'hFFF);   // pulse rises, full-scale peak
    put_item(CMD_TICK, 12'd3000);
    put_item(CMD_TICK, 12'h000);   // pulse falls
    put_item(CMD_TICK, 12'h000);   // top turning point, good pulse
    put_item(CMD_TICK, 12'd2049);  // just above trigger
    put_item(CMD_TICK, 12'd2048);  // at trigger, pulse holds
    put_item(CMD_TICK, 12'd2047);
    put_item(CMD_TICK, 12'h000);
    put_item(CMD_TICK, 12'h000);   // low peak: miss
    repeat (5) put_item(CMD_TICK, 12'h555);
    repeat (5) put_item(CMD_TICK, 12'hAAA);  // miss limit hit, alarm raised
    put_item(CMD_CLEAR, 12'h000);
    put_item(CMD_STOP, 12'h000);
    put_item(CMD_START, 12'hFFF);  // peak seeded by the start sample
    wait_results();

    set_regs(12'd2048, 12'd3000, 8'd4, 12'd420, 12'd400, 12'd1600, 8'd40);
    run_random(250, 1'b1, 60);
    wait_results();

    // every tick sits on a turning point
    set_regs(12'd0, 12'd0, 8'd0, 12'd0, 12'd0, 12'd0, 8'd255);
    run_random(100, 1'b1, -1);
    wait_results();

    // upward steps saturate at full scale
    set_regs(12'hFFF, 12'hFFF, 8'hFF, 12'hFFF, 12'd4000, 12'hFFF, 8'd255);
    run_random(150, 1'b1, -1);
    wait_results();

    // low point above the high point, ramp carried over from the last setting
    set_regs(12'd1500, 12'd2500, 8'd3, 12'd2000, 12'd3000, 12'd1000, 8'd17);
    run_random(150, 1'b0, -1);
    wait_results();

    // ramp frozen
    set_regs(12'd2048, 12'd2500, 8'd2, 12'd100, 12'd500, 12'd600, 8'd0);
    run_random(80, 1'b0, -1);
    wait_results();

    repeat (6) begin
      pick_random_regs();
      run_random(130, 1'($urandom_range(0, 1)), -1);
      wait_results();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
